[rtl/sliding_window_sender_fast_retransmit_macros.svh]
// ----------------------------------------------------------------------------
// sliding window sender macros
// assertion helpers used by the sender control rtl (swsfr_ctrl)
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SENDER_FAST_RETRANSMIT_MACROS_SVH
`define SLIDING_WINDOW_SENDER_FAST_RETRANSMIT_MACROS_SVH

// same-cycle implication
`define SWSFR_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWSFR_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/swsfr_pkg.sv]
// ----------------------------------------------------------------------------
// swsfr_pkg
// types and constants of the sliding window sender
// ----------------------------------------------------------------------------
package swsfr_pkg;

  localparam int SEQ_SPACE    = 8;
  localparam int SEQ_BITS     = 3;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_BITS     = 2;
  localparam int WLEN_BITS    = 3;

  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [CNT_BITS-1:0]  DUP_LIMIT   = 2'd3;
  localparam logic [WLEN_BITS-1:0] WLEN_RESET  = 3'd4;
  localparam logic [SEQ_BITS-1:0]  BASE_RESET  = 3'd1;
  localparam logic [SEQ_BITS-1:0]  NEXT_RESET  = 3'd1;
  localparam logic [SEQ_BITS-1:0]  TIMED_RESET = 3'd0;
  localparam logic [SEQ_BITS-1:0]  SEQ_ONE     = 3'd1;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_BITS-1:0]     ack_num;
    logic                    ack_checksum_ok;
    logic [SEQ_BITS-1:0]     expired_seq;
  } in_item_t;

  typedef struct packed {
    logic                    accepted;
    logic                    window_full;
    logic                    tx_valid;
    logic [SEQ_BITS-1:0]     tx_seq;
    logic [PAYLOAD_BITS-1:0] tx_payload;
    logic                    timer_stop;
    logic [SEQ_BITS-1:0]     timer_stop_seq;
    logic                    timer_start;
    logic [SEQ_BITS-1:0]     timer_start_seq;
  } out_item_t;

  typedef struct packed {
    logic                en;
    logic [SEQ_BITS-1:0] pkt_addr;
    logic [SEQ_BITS-1:0] cnt_addr;
  } rd_req_t;

  typedef struct packed {
    logic                    we;
    logic [SEQ_BITS-1:0]     addr;
    logic [PAYLOAD_BITS-1:0] data;
  } pkt_wr_t;

  typedef struct packed {
    logic                we;
    logic [SEQ_BITS-1:0] addr;
    logic [CNT_BITS-1:0] data;
  } cnt_wr_t;

endpackage

[rtl/swsfr_ram.sv]
// ----------------------------------------------------------------------------
// swsfr_ram
// one write port, one registered read port, write-first on address match,
// optional per-entry valid bits so unwritten entries read as zero
// ----------------------------------------------------------------------------
module swsfr_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  parameter bit CLEAR = 1'b0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_raw;
  logic             hit;

  assign hit = we && (waddr == raddr);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_raw <= hit ? wdata : mem[raddr];
    end
  end

  if (CLEAR) begin : g_clear
    logic [DEPTH-1:0] valid;
    logic             rd_ok;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid <= '0;
      end else if (we) begin
        valid[waddr] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (re) begin
        rd_ok <= hit || valid[raddr];
      end
    end

    assign rdata = rd_ok ? rdata_raw : '0;
  end else begin : g_plain
    assign rdata = rdata_raw;
  end

endmodule

[rtl/swsfr_ctrl.sv]
// ----------------------------------------------------------------------------
// swsfr_ctrl
// window state, event stage and result register of the sender
// ----------------------------------------------------------------------------
`include "sliding_window_sender_fast_retransmit_macros.svh"

module swsfr_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [swsfr_pkg::WLEN_BITS-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  swsfr_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output swsfr_pkg::out_item_t                 out_item,
  output swsfr_pkg::rd_req_t                   rd_req,
  output swsfr_pkg::pkt_wr_t                   pkt_wr,
  output swsfr_pkg::cnt_wr_t                   cnt_wr,
  input  logic [swsfr_pkg::PAYLOAD_BITS-1:0]   pkt_rdata,
  input  logic [swsfr_pkg::CNT_BITS-1:0]       cnt_rdata
);
  import swsfr_pkg::*;

  logic [WLEN_BITS-1:0] wlen;
  logic [SEQ_BITS-1:0]  base, base_next;
  logic [SEQ_BITS-1:0]  nxt, nxt_next;
  logic [SEQ_BITS-1:0]  timed, timed_next;

  in_item_t  s1_item;
  logic      s1_valid;
  out_item_t res;

  logic stall, s1_fire, in_fire;

  logic [SEQ_BITS-1:0] inflight, win_end, off, occ_next;
  logic                dup;
  logic [CNT_BITS-1:0] cnt_inc;

  assign stall    = out_valid && !out_ready;
  assign s1_fire  = s1_valid && !stall;
  assign in_ready = !(s1_valid && stall);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    inflight   = nxt - base;
    win_end    = base + wlen;
    off        = s1_item.ack_num - base;
    cnt_inc    = cnt_rdata + 2'd1;
    dup        = (base < win_end) ? (s1_item.ack_num <= base)
                                  : ((s1_item.ack_num <= base) && (s1_item.ack_num > win_end));
    base_next  = base;
    nxt_next   = nxt;
    timed_next = timed;
    res        = '0;
    pkt_wr     = '0;
    cnt_wr     = '0;
    case (s1_item.cmd)
      CMD_SEND: begin
        if (inflight < wlen) begin
          res.accepted   = 1'b1;
          pkt_wr.we      = s1_fire;
          pkt_wr.addr    = nxt;
          pkt_wr.data    = s1_item.payload;
          res.tx_valid   = 1'b1;
          res.tx_seq     = nxt;
          res.tx_payload = s1_item.payload;
          nxt_next       = nxt + SEQ_ONE;
          if (base == nxt) begin
            timed_next          = base;
            res.timer_start     = 1'b1;
            res.timer_start_seq = base;
          end
        end
      end
      CMD_ACK: begin
        if (s1_item.ack_checksum_ok) begin
          if (!dup) begin
            base_next          = s1_item.ack_num;
            res.timer_stop     = 1'b1;
            res.timer_stop_seq = timed;
            if (s1_item.ack_num != nxt) begin
              timed_next          = s1_item.ack_num;
              res.timer_start     = 1'b1;
              res.timer_start_seq = s1_item.ack_num;
            end
          end else begin
            cnt_wr.we   = s1_fire;
            cnt_wr.addr = s1_item.ack_num;
            cnt_wr.data = cnt_inc;
            if (cnt_inc == DUP_LIMIT) begin
              cnt_wr.data = '0;
              if (off < inflight) begin
                res.tx_valid   = 1'b1;
                res.tx_seq     = s1_item.ack_num;
                res.tx_payload = pkt_rdata;
              end
            end
          end
        end
      end
      CMD_TIMEOUT: begin
        res.timer_stop     = 1'b1;
        res.timer_stop_seq = s1_item.expired_seq;
        if (base != nxt) begin
          res.tx_valid        = 1'b1;
          res.tx_seq          = base;
          res.tx_payload      = pkt_rdata;
          res.timer_start     = 1'b1;
          res.timer_start_seq = base;
        end
      end
      default: begin
      end
    endcase
    occ_next        = nxt_next - base_next;
    res.window_full = (occ_next >= wlen);
  end

  // reads are issued at transfer, against the window as it stands after the stage ahead
  always_comb begin
    rd_req.en       = in_fire;
    rd_req.pkt_addr = (in_item.cmd == CMD_ACK) ? in_item.ack_num
                                               : (s1_fire ? base_next : base);
    rd_req.cnt_addr = in_item.ack_num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen <= WLEN_RESET;
    end else if (cfg_we) begin
      wlen <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= BASE_RESET;
      nxt   <= NEXT_RESET;
      timed <= TIMED_RESET;
    end else if (s1_fire) begin
      base  <= base_next;
      nxt   <= nxt_next;
      timed <= timed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item <= res;
    end
  end

  `SWSFR_CHECK(a_stall_only_when_full, !in_ready, s1_valid && out_valid, "input stalled with room")
  `SWSFR_CHECK(a_accept_sends, out_valid && out_item.accepted, out_item.tx_valid, "accepted without tx")
  `SWSFR_CHECK(a_count_cleared, cnt_wr.we, cnt_wr.data != DUP_LIMIT, "duplicate count stored at limit")
  `SWSFR_CHECK_NEXT(a_seq_advance, s1_fire && res.accepted, nxt == $past(nxt) + SEQ_ONE, "next sequence did not advance")

endmodule

[rtl/sliding_window_sender_fast_retransmit.sv]
// ----------------------------------------------------------------------------
// sliding_window_sender_fast_retransmit
// window sender with cumulative ack, timer events and fast retransmit
// ----------------------------------------------------------------------------
// Takes one event per clock while the output is not stalled (send offer,
// ack, timer expiry) and returns one result for each, through the event
// stage and then the result register. Each event reads the packet store
// and the duplicate count store, issued at transfer, and the update stage
// writes both back; same-entry accesses of neighboring events
// are forwarded inside the stores. The duplicate counts read as zero after
// reset through per-entry valid bits, so there is no clearing pass. The
// window length register may be written only while no event is in flight.
module sliding_window_sender_fast_retransmit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [swsfr_pkg::WLEN_BITS-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  swsfr_pkg::in_item_t                in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output swsfr_pkg::out_item_t               out_item
);
  import swsfr_pkg::*;

  rd_req_t                 rd_req;
  pkt_wr_t                 pkt_wr;
  cnt_wr_t                 cnt_wr;
  logic [PAYLOAD_BITS-1:0] pkt_rdata;
  logic [CNT_BITS-1:0]     cnt_rdata;

  swsfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .rd_req    (rd_req),
    .pkt_wr    (pkt_wr),
    .cnt_wr    (cnt_wr),
    .pkt_rdata (pkt_rdata),
    .cnt_rdata (cnt_rdata)
  );

  swsfr_ram #(
    .DEPTH (SEQ_SPACE),
    .WIDTH (PAYLOAD_BITS),
    .CLEAR (1'b0)
  ) u_pkt_store (
    .clk   (clk),
    .rst   (rst),
    .we    (pkt_wr.we),
    .waddr (pkt_wr.addr),
    .wdata (pkt_wr.data),
    .re    (rd_req.en),
    .raddr (rd_req.pkt_addr),
    .rdata (pkt_rdata)
  );

  swsfr_ram #(
    .DEPTH (SEQ_SPACE),
    .WIDTH (CNT_BITS),
    .CLEAR (1'b1)
  ) u_dup_counts (
    .clk   (clk),
    .rst   (rst),
    .we    (cnt_wr.we),
    .waddr (cnt_wr.addr),
    .wdata (cnt_wr.data),
    .re    (rd_req.en),
    .raddr (rd_req.cnt_addr),
    .rdata (cnt_rdata)
  );

endmodule

[tb/sliding_window_sender_fast_retransmit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_sender_fast_retransmit_tb
// self-checking testbench of the sliding window sender
// ----------------------------------------------------------------------------
// Runs a directed sequence through window fill, refused offers, bad and
// duplicate acks, fast retransmit, timeouts and acks that jump past the
// window, then random traffic under several window lengths and idle
// patterns, a long output hold-off and a full drain pause. A behavioral
// model of the window state predicts every result, which is compared field
// by field with what the block returns.
// ----------------------------------------------------------------------------
module sliding_window_sender_fast_retransmit_tb;
  import swsfr_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 90;
  localparam int END_CYCLES = 10;
  localparam int EXP_DEPTH = 16;

  typedef logic [SEQ_BITS-1:0] seq_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [WLEN_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  // window model
  logic [WLEN_BITS-1:0] window_len;
  seq_t seq_base;
  seq_t seq_next;
  seq_t seq_timed;
  logic [PAYLOAD_BITS-1:0] pkt_store [SEQ_SPACE];
  logic [CNT_BITS-1:0] dup_count [SEQ_SPACE];
  bit pkt_written [SEQ_SPACE];

  // expected results, written by the sender and read by the checker
  out_item_t exp_fifo [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_tag = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int n_errors = 0;
  int n_events = 0;
  int n_results = 0;
  int n_fast_rtx = 0;
  int n_timeout_rtx = 0;
  int n_refused = 0;

  sliding_window_sender_fast_retransmit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic seq_t occupancy();
    return seq_next - seq_base;
  endfunction

  function automatic bit is_duplicate(input seq_t a);
    seq_t win_end;
    win_end = seq_base + seq_t'(window_len);
    if (seq_base < win_end) begin
      return a <= seq_base;
    end
    return (a <= seq_base) && (a > win_end);
  endfunction

  // true when the event would retransmit a store entry never written
  function automatic bit reads_unwritten_entry(input in_item_t it);
    logic [CNT_BITS-1:0] c;
    seq_t off;
    if (it.cmd == CMD_TIMEOUT) begin
      return (seq_base != seq_next) && !pkt_written[seq_base];
    end
    if (it.cmd != CMD_ACK || !it.ack_checksum_ok || !is_duplicate(it.ack_num)) begin
      return 1'b0;
    end
    c = dup_count[it.ack_num] + 2'd1;
    off = it.ack_num - seq_base;
    return (c == DUP_LIMIT) && (off < occupancy()) && !pkt_written[it.ack_num];
  endfunction

  function automatic out_item_t advance_sender(input in_item_t it);
    out_item_t r;
    seq_t a;
    seq_t off;
    logic [CNT_BITS-1:0] c;
    r = '0;
    a = it.ack_num;
    case (it.cmd)
      CMD_SEND: begin
        if (occupancy() < seq_t'(window_len)) begin
          r.accepted = 1'b1;
          pkt_store[seq_next] = it.payload;
          pkt_written[seq_next] = 1'b1;
          if (seq_base == seq_next) begin
            seq_timed = seq_base;
            r.timer_start = 1'b1;
            r.timer_start_seq = seq_base;
          end
          r.tx_valid = 1'b1;
          r.tx_seq = seq_next;
          r.tx_payload = it.payload;
          seq_next = seq_next + SEQ_ONE;
        end else begin
          n_refused++;
        end
      end
      CMD_ACK: begin
        if (it.ack_checksum_ok) begin
          if (!is_duplicate(a)) begin
            seq_base = a;
            r.timer_stop = 1'b1;
            r.timer_stop_seq = seq_timed;
            if (seq_base != seq_next) begin
              seq_timed = seq_base;
              r.timer_start = 1'b1;
              r.timer_start_seq = seq_base;
            end
          end else begin
            c = dup_count[a] + 2'd1;
            dup_count[a] = c;
            if (c == DUP_LIMIT) begin
              off = a - seq_base;
              if (off < occupancy()) begin
                r.tx_valid = 1'b1;
                r.tx_seq = a;
                r.tx_payload = pkt_store[a];
                n_fast_rtx++;
              end
              dup_count[a] = '0;
            end
          end
        end
      end
      CMD_TIMEOUT: begin
        r.timer_stop = 1'b1;
        r.timer_stop_seq = it.expired_seq;
        if (seq_base != seq_next) begin
          r.tx_valid = 1'b1;
          r.tx_seq = seq_base;
          r.tx_payload = pkt_store[seq_base];
          r.timer_start = 1'b1;
          r.timer_start_seq = seq_base;
          n_timeout_rtx++;
        end
      end
      default: begin
      end
    endcase
    r.window_full = occupancy() >= seq_t'(window_len);
    return r;
  endfunction

  function automatic in_item_t make_event(input logic [1:0] cmd,
                                          input logic [PAYLOAD_BITS-1:0] payload,
                                          input seq_t ack, input logic ck,
                                          input seq_t expired);
    in_item_t it;
    it.cmd = cmd;
    it.payload = payload;
    it.ack_num = ack;
    it.ack_checksum_ok = ck;
    it.expired_seq = expired;
    return it;
  endfunction

  // mostly well-formed traffic around the current window, some noise
  function automatic in_item_t random_event(input int r);
    in_item_t it;
    seq_t fl;
    int off_i;
    it.cmd = CMD_SEND;
    it.payload = $urandom;
    it.ack_num = seq_t'($urandom);
    it.ack_checksum_ok = 1'($urandom_range(0, 1));
    it.expired_seq = seq_t'($urandom);
    fl = occupancy();
    if (r < 40) begin
      it.cmd = CMD_SEND;
    end else if (r < 58) begin
      if (fl != 0) begin
        off_i = $urandom_range(1, int'(fl));
        it.cmd = CMD_ACK;
        it.ack_checksum_ok = 1'b1;
        it.ack_num = seq_base + seq_t'(off_i);
      end
    end else if (r < 72) begin
      it.cmd = CMD_ACK;
      it.ack_checksum_ok = 1'b1;
      it.ack_num = seq_base;
    end else if (r < 82) begin
      it.cmd = CMD_TIMEOUT;
      if ($urandom_range(0, 1) == 1) begin
        it.expired_seq = seq_timed;
      end
    end else if (r < 89) begin
      it.cmd = CMD_ACK;
      it.ack_checksum_ok = 1'b0;
    end else if (r < 93) begin
      it.cmd = CMD_NONE;
    end else begin
      it.cmd = CMD_ACK;
      it.ack_checksum_ok = 1'b1;
    end
    return it;
  endfunction

  task automatic send_event(input in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct && gap < 40) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_fifo[exp_wr % EXP_DEPTH] = advance_sender(it);
    exp_wr++;
    n_events++;
  endtask

  task automatic send_guarded(input in_item_t it);
    if (reads_unwritten_entry(it)) begin
      it.cmd = CMD_SEND;
    end
    send_event(it);
  endtask

  task automatic send_random(input int count);
    int sent;
    int r;
    int reps;
    in_item_t it;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      it = random_event(r);
      reps = (r >= 58 && r < 72) ? 3 : 1;
      repeat (reps) begin
        send_guarded(it);
        sent++;
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window_len(input logic [WLEN_BITS-1:0] wl);
    cfg_we <= 1'b1;
    cfg_data <= wl;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_len = wl;
  endtask

  task automatic set_idle(input int sender_pct, input int recv_pct);
    sender_idle_pct = sender_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_directed();
    set_idle(0, 0);
    send_event(make_event(CMD_TIMEOUT, '0, '0, 1'b1, 3'd0));
    send_event(make_event(CMD_SEND, 32'h0000_0000, 3'd7, 1'b0, 3'd7));
    send_event(make_event(CMD_SEND, 32'hFFFF_FFFF, 3'd0, 1'b1, 3'd0));
    send_event(make_event(CMD_SEND, 32'hA5A5_5A5A, 3'd5, 1'b0, 3'd2));
    send_event(make_event(CMD_SEND, 32'h1234_5678, 3'd2, 1'b1, 3'd5));
    send_event(make_event(CMD_SEND, 32'hDEAD_BEEF, 3'd1, 1'b1, 3'd1));
    send_event(make_event(CMD_ACK, 32'hFFFF_FFFF, 3'd1, 1'b0, 3'd7));
    send_event(make_event(CMD_NONE, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7));
    repeat (3) send_event(make_event(CMD_ACK, '0, 3'd1, 1'b1, 3'd0));
    send_event(make_event(CMD_TIMEOUT, '0, 3'd0, 1'b0, 3'd7));
    send_event(make_event(CMD_ACK, '0, 3'd3, 1'b1, 3'd0));
    send_event(make_event(CMD_ACK, '0, 3'd0, 1'b1, 3'd0));
    send_event(make_event(CMD_ACK, '0, 3'd5, 1'b1, 3'd0));
    send_event(make_event(CMD_TIMEOUT, '0, 3'd0, 1'b1, 3'd5));
    // ack jumping past the next sequence number, then back into range
    send_event(make_event(CMD_ACK, '0, 3'd7, 1'b1, 3'd0));
    send_event(make_event(CMD_ACK, '0, 3'd5, 1'b1, 3'd0));
    send_event(make_event(CMD_SEND, 32'h5555_AAAA, 3'd0, 1'b0, 3'd0));
    send_event(make_event(CMD_ACK, '0, 3'd1, 1'b1, 3'd0));
    send_event(make_event(CMD_TIMEOUT, '0, 3'd0, 1'b1, 3'd3));
    send_event(make_event(CMD_ACK, '0, 3'd5, 1'b1, 3'd0));
  endtask

  task automatic test_random_phase(input logic [WLEN_BITS-1:0] wl, input int sender_pct,
                                   input int recv_pct, input int count);
    settle();
    write_window_len(wl);
    set_idle(sender_pct, recv_pct);
    send_random(count);
  endtask

  task automatic test_output_holdoff();
    settle();
    set_idle(0, 0);
    @(negedge clk);
    hold_tag++;
    @(posedge clk);
    send_random(30);
  endtask

  task automatic test_sender_pause();
    settle();
    write_window_len(3'd6);
    set_idle(24, 24);
    send_random(12);
    settle();
    send_random(12);
  endtask

  // receiver side, with its own count of a requested hold-off
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (exp_wr == exp_rd) begin
        if (n_errors < 10) begin
          $display("unexpected result transfer: %h", out_item);
        end
        n_errors++;
      end else begin
        exp_r = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_item.accepted !== exp_r.accepted ||
            out_item.window_full !== exp_r.window_full ||
            out_item.tx_valid !== exp_r.tx_valid ||
            out_item.tx_seq !== exp_r.tx_seq ||
            out_item.tx_payload !== exp_r.tx_payload ||
            out_item.timer_stop !== exp_r.timer_stop ||
            out_item.timer_stop_seq !== exp_r.timer_stop_seq ||
            out_item.timer_start !== exp_r.timer_start ||
            out_item.timer_start_seq !== exp_r.timer_start_seq) begin
          if (n_errors < 10) begin
            $display("mismatch at result %0d", n_results);
            $display("  exp acc=%b full=%b tx=%b/%0d/%h stop=%b/%0d start=%b/%0d",
                     exp_r.accepted, exp_r.window_full, exp_r.tx_valid, exp_r.tx_seq,
                     exp_r.tx_payload, exp_r.timer_stop, exp_r.timer_stop_seq,
                     exp_r.timer_start, exp_r.timer_start_seq);
            $display("  got acc=%b full=%b tx=%b/%0d/%h stop=%b/%0d start=%b/%0d",
                     out_item.accepted, out_item.window_full, out_item.tx_valid,
                     out_item.tx_seq, out_item.tx_payload, out_item.timer_stop,
                     out_item.timer_stop_seq, out_item.timer_start,
                     out_item.timer_start_seq);
          end
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (!rst && out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", stall_cycles);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    window_len = WLEN_RESET;
    seq_base = BASE_RESET;
    seq_next = NEXT_RESET;
    seq_timed = TIMED_RESET;
    for (int i = 0; i < SEQ_SPACE; i++) begin
      pkt_store[i] = '0;
      dup_count[i] = '0;
      pkt_written[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_phase(3'd7, 0, 0, 100);
    test_random_phase(3'd1, 47, 0, 100);
    test_random_phase(3'd3, 0, 47, 100);
    test_random_phase(3'd7, 24, 24, 100);
    test_random_phase(3'd2, 0, 0, 80);
    test_random_phase(3'd1, 24, 24, 60);
    test_random_phase(3'd5, 47, 0, 60);
    test_output_holdoff();
    test_sender_pause();

    settle();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d events and %0d results over window lengths 1 to 7 and four idle mixes",
             n_events, n_results);
    $display("fast retransmits %0d, timeout retransmits %0d, refused offers %0d, errors %0d",
             n_fast_rtx, n_timeout_rtx, n_refused, n_errors);
    if (n_errors == 0 && exp_wr == exp_rd) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
